// ===== design/isp_programming_target_unit_macros.svh =====
// Assertion macros shared by the checker of the programming target.
// Each macro is one labeled concurrent assertion clocked on clk.
`ifndef ISP_PROGRAMMING_TARGET_UNIT_MACROS_SVH
`define ISP_PROGRAMMING_TARGET_UNIT_MACROS_SVH
// implication within the same edge
`define ISP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("isp check failed");
// implication at the following edge
`define ISP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("isp check failed");
`endif

// ===== design/isp_pkg.sv =====
// Shared types and constants of the programming target.
// No dependencies.
`timescale 1ns / 1ps
package isp_pkg;
	localparam int PageWords   = 32;
	localparam int FlashPages  = 128;
	localparam int EepromBytes = 512;
	localparam int FlashWords  = PageWords * FlashPages;
	localparam int PwW = $clog2(PageWords);
	localparam int PgW = $clog2(FlashPages);
	localparam int FwW = $clog2(FlashWords);
	localparam int EeW = $clog2(EepromBytes);

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_IGNORED = 2'd1;
	localparam logic [1:0] ST_UNKNOWN = 2'd2;

	localparam logic [7:0] OP_AC = 8'hAC;
	localparam logic [7:0] OP_SIG = 8'h30;
	localparam logic [7:0] OP_FRL = 8'h20;
	localparam logic [7:0] OP_FRH = 8'h28;
	localparam logic [7:0] OP_PLL = 8'h40;
	localparam logic [7:0] OP_PLH = 8'h48;
	localparam logic [7:0] OP_PCM = 8'h4C;
	localparam logic [7:0] OP_EER = 8'hA0;
	localparam logic [7:0] OP_EEW = 8'hC0;
	localparam logic [7:0] OP_FLR = 8'h50;
	localparam logic [7:0] OP_FHR = 8'h58;
	localparam logic [7:0] OP_LKW = 8'h5C;
	localparam logic [7:0] SUB_EN = 8'h53;
	localparam logic [7:0] SUB_ER = 8'h80;
	localparam logic [7:0] SUB_FW = 8'hA0;

	localparam logic [1:0] CFG_SIG0 = 2'd0;
	localparam logic [1:0] CFG_SIG1 = 2'd1;
	localparam logic [1:0] CFG_SIG2 = 2'd2;
	localparam logic [1:0] CFG_FH   = 2'd3;

	typedef enum logic [3:0] {
		K_NONE, K_ERASE, K_FUSEW, K_SIG, K_FLR, K_PLOAD, K_COMMIT,
		K_EER, K_EEW, K_FUSER, K_HIR, K_LOCKR, K_LOCKW
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic       hi;
		logic [7:0] b1;
		logic [7:0] b2;
		logic [7:0] b3;
		logic [1:0] st;
	} cmd_t;

	typedef struct packed {
		logic [7:0] echo_byte;
		logic [7:0] read_data;
		logic [1:0] status;
	} rsp_t;
endpackage

// ===== design/isp_if.sv =====
// Valid/ready channel interfaces of the programming target.
// No dependencies.
`timescale 1ns / 1ps
interface isp_req_if;
	logic       valid;
	logic       ready;
	logic [7:0] req_type;
	logic [7:0] byte_one;
	logic [7:0] byte_two;
	logic [7:0] byte_three;
	modport source (output valid, req_type, byte_one, byte_two, byte_three, input ready);
	modport sink (input valid, req_type, byte_one, byte_two, byte_three, output ready);
endinterface

interface isp_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] echo_byte;
	logic [7:0] read_data;
	logic [1:0] status;
	modport source (output valid, echo_byte, read_data, status, input ready);
	modport sink (input valid, echo_byte, read_data, status, output ready);
endinterface

interface isp_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] index;
	logic [7:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== design/isp_front.sv =====
// Front end: takes frames, tracks the enable flag, classifies commands.
// Depends on isp_pkg.
`timescale 1ns / 1ps
module isp_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [7:0]       req_type,
	input  logic [7:0]       byte_one,
	input  logic [7:0]       byte_two,
	input  logic [7:0]       byte_three,
	output logic             q_push,
	input  logic             q_full,
	output isp_pkg::cmd_t    q_cmd
);
	logic              en_q;
	logic              en_now;
	isp_pkg::kind_t    k;
	logic [1:0]        st;

	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;
	assign en_now   = en_q || (req_type == isp_pkg::OP_AC && byte_one == isp_pkg::SUB_EN);

	always_comb begin
		k  = isp_pkg::K_NONE;
		st = isp_pkg::ST_OK;
		case (req_type)
			isp_pkg::OP_AC: begin
				if (byte_one == isp_pkg::SUB_EN) k = isp_pkg::K_NONE;
				else if (byte_one == isp_pkg::SUB_ER) k = isp_pkg::K_ERASE;
				else if (byte_one == isp_pkg::SUB_FW) k = isp_pkg::K_FUSEW;
				else st = isp_pkg::ST_UNKNOWN;
			end
			isp_pkg::OP_SIG: k = isp_pkg::K_SIG;
			isp_pkg::OP_FRL, isp_pkg::OP_FRH: k = isp_pkg::K_FLR;
			isp_pkg::OP_PLL, isp_pkg::OP_PLH: k = isp_pkg::K_PLOAD;
			isp_pkg::OP_PCM: k = isp_pkg::K_COMMIT;
			isp_pkg::OP_EER: k = isp_pkg::K_EER;
			isp_pkg::OP_EEW: k = isp_pkg::K_EEW;
			isp_pkg::OP_FLR: k = isp_pkg::K_FUSER;
			isp_pkg::OP_FHR: k = byte_one[3] ? isp_pkg::K_HIR : isp_pkg::K_LOCKR;
			isp_pkg::OP_LKW: k = isp_pkg::K_LOCKW;
			default: st = isp_pkg::ST_UNKNOWN;
		endcase
		if (!en_now) begin
			k  = isp_pkg::K_NONE;
			st = isp_pkg::ST_IGNORED;
		end
		q_cmd.kind = k;
		q_cmd.hi   = req_type[3];
		q_cmd.b1   = en_now ? byte_one : 8'd0;
		q_cmd.b2   = byte_two;
		q_cmd.b3   = byte_three;
		q_cmd.st   = st;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) en_q <= 1'b0;
		else if (q_push) en_q <= en_now;
	end
endmodule

// ===== design/isp_queue.sv =====
// Two-entry command queue between front and back end.
// Depends on isp_pkg.
`timescale 1ns / 1ps
module isp_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  isp_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output logic          not_empty,
	output isp_pkg::cmd_t head
);
	isp_pkg::cmd_t mem_q [2];
	logic          wp_q, rp_q;
	logic [1:0]    cnt_q;

	assign full      = cnt_q == 2'd2;
	assign not_empty = cnt_q != 2'd0;
	assign head      = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

// ===== design/isp_back.sv =====
// Back end: executes commands on page buffer, flash, EEPROM and fuse registers.
// Depends on isp_pkg. Flash and EEPROM are cleared by sweeps (reset, chip erase).
`timescale 1ns / 1ps
module isp_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	input  isp_pkg::cmd_t cmd,
	output logic          cmd_pop,
	input  logic [7:0]    sig0,
	input  logic [7:0]    sig1,
	input  logic [7:0]    sig2,
	input  logic [7:0]    fuse_hi,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output isp_pkg::rsp_t rsp
);
	typedef enum logic [2:0] {S_CLR, S_IDLE, S_RD, S_CRD, S_CWR, S_OUT} state_t;

	logic [15:0] flash_mem [isp_pkg::FlashWords];
	logic [7:0]  ee_mem [isp_pkg::EepromBytes];
	logic [15:0] pbuf_mem [isp_pkg::PageWords];

	state_t            state_q;
	logic [isp_pkg::FwW:0] clr_q;
	logic [isp_pkg::PwW:0] cp_q;
	logic [7:0]        fuse_lo_q, lock_q;
	isp_pkg::cmd_t     cur_q;
	logic [15:0]       frd_q, pbrd_q;
	logic [7:0]        erd_q;
	isp_pkg::rsp_t     rsp_q;
	logic              rv_q;
	logic              arst_q_done;

	logic [15:0]             caddr, cur_addr;
	logic [isp_pkg::FwW-1:0] faddr;
	logic [isp_pkg::EeW-1:0] eaddr;
	logic [isp_pkg::PwW-1:0] paddr;
	logic [15:0]             fw;
	logic [isp_pkg::PgW-1:0] page;
	logic                    take;
	logic [7:0]              rd;

	assign caddr    = {cmd.b1, cmd.b2};
	assign cur_addr = {cur_q.b1, cur_q.b2};
	assign faddr = caddr[isp_pkg::FwW-1:0];
	assign eaddr = caddr[isp_pkg::EeW-1:0];
	assign paddr = cmd.b2[isp_pkg::PwW-1:0];
	assign page  = cur_addr[isp_pkg::FwW-1:isp_pkg::PwW];
	assign take  = state_q == S_IDLE && cmd_valid && !rv_q;
	assign cmd_pop = take;
	assign rsp_valid = rv_q;
	assign rsp = rsp_q;

	// page load merges the new byte into the word read at take
	always_comb begin
		fw = pbrd_q;
		if (cur_q.hi) fw[15:8] = cur_q.b3; else fw[7:0] = cur_q.b3;
	end

	always_comb begin
		case (cur_q.kind)
			isp_pkg::K_SIG: begin
				case (cur_q.b2[1:0])
					2'd0: rd = sig0;
					2'd1: rd = sig1;
					2'd2: rd = sig2;
					default: rd = 8'd0;
				endcase
			end
			isp_pkg::K_FLR: rd = cur_q.hi ? frd_q[15:8] : frd_q[7:0];
			isp_pkg::K_EER: rd = erd_q;
			isp_pkg::K_FUSER: rd = fuse_lo_q;
			isp_pkg::K_HIR: rd = fuse_hi;
			isp_pkg::K_LOCKR: rd = lock_q;
			default: rd = 8'd0;
		endcase
	end

	// memories: one write port each, registered read
	always_ff @(posedge clk) begin
		frd_q  <= flash_mem[faddr];
		erd_q  <= ee_mem[eaddr];
		pbrd_q <= pbuf_mem[take ? paddr : cp_q[isp_pkg::PwW-1:0]];
		if (state_q == S_CLR) begin
			flash_mem[clr_q[isp_pkg::FwW-1:0]] <= 16'hFFFF;
			if (clr_q < (isp_pkg::FwW+1)'(isp_pkg::EepromBytes))
				ee_mem[clr_q[isp_pkg::EeW-1:0]] <= 8'hFF;
			if (clr_q < (isp_pkg::FwW+1)'(isp_pkg::PageWords) && !arst_q_done)
				pbuf_mem[clr_q[isp_pkg::PwW-1:0]] <= 16'hFFFF;
		end
		if (state_q == S_RD && cur_q.kind == isp_pkg::K_PLOAD)
			pbuf_mem[cur_q.b2[isp_pkg::PwW-1:0]] <= fw;
		if (state_q == S_RD && cur_q.kind == isp_pkg::K_EEW)
			ee_mem[cur_addr[isp_pkg::EeW-1:0]] <= cur_q.b3;
		if (state_q == S_CWR)
			flash_mem[{page, cp_q[isp_pkg::PwW-1:0]}] <= pbrd_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR; clr_q <= '0; cp_q <= '0; arst_q_done <= 1'b0;
			fuse_lo_q <= 8'hE1; lock_q <= 8'hFF; rv_q <= 1'b0;
			cur_q <= '0; rsp_q <= '0;
		end else begin
			if (rv_q && rsp_ready) rv_q <= 1'b0;
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (isp_pkg::FwW+1)'(isp_pkg::FlashWords - 1)) begin
						state_q <= S_IDLE; arst_q_done <= 1'b1;
					end
				end
				S_IDLE: if (take) begin
					cur_q   <= cmd;
					state_q <= S_RD;
				end
				S_RD: begin
					if (cur_q.kind == isp_pkg::K_FUSEW) fuse_lo_q <= cur_q.b3;
					if (cur_q.kind == isp_pkg::K_LOCKW) lock_q <= cur_q.b3;
					rsp_q.echo_byte <= cur_q.b1;
					rsp_q.read_data <= rd;
					rsp_q.status    <= cur_q.st;
					if (cur_q.kind == isp_pkg::K_ERASE) begin
						clr_q <= '0; state_q <= S_CLR; rv_q <= 1'b1;
					end else if (cur_q.kind == isp_pkg::K_COMMIT) begin
						cp_q <= '0; state_q <= S_CRD;
					end else begin
						state_q <= S_IDLE; rv_q <= 1'b1;
					end
				end
				S_CRD: state_q <= S_CWR;
				S_CWR: begin
					if (cp_q == (isp_pkg::PwW+1)'(isp_pkg::PageWords - 1)) begin
						state_q <= S_IDLE; rv_q <= 1'b1; cp_q <= '0;
					end else begin
						cp_q <= cp_q + 1'b1;
						state_q <= S_CRD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== design/isp_programming_target_unit.sv =====
// Top level of the serial programming target.
// Depends on isp_pkg, isp_if, isp_front, isp_queue, isp_back.
`timescale 1ns / 1ps
// Usage:
//  req  : one four-byte frame per request (req_type, byte_one..byte_three).
//  rsp  : one response per frame (echo_byte, read_data, status), in order.
//  cfg  : writes the signature bytes (index 0..2) and the high fuse (3).
//         Write only while idle.
// Structure: a front end classifies frames and tracks the enable flag, a
//  two-entry queue decouples it from the back end that touches the stores.
// Flow: a plain frame passes the queue, the command register and the
//  output register before its response is valid. The back end takes the
//  next frame only once the response has left, so it never works on two
//  frames at once. A page commit reads each page word from the buffer and
//  then writes it to flash, word by word. A chip erase responds at once,
//  then sweeps flash and EEPROM to ones, one flash word per cycle, before
//  the next frame runs.
// Reset: the same sweep fills flash, EEPROM and page buffer
//  with ones; frames queue up meanwhile and run once it ends.
// Stall: a held response stops the back end; the queue then fills and
//  req.ready drops.
module isp_programming_target_unit (
	input logic clk,
	input logic arst_n,
	isp_req_if.sink   req,
	isp_rsp_if.source rsp,
	isp_cfg_if.sink   cfg
);
	isp_pkg::cmd_t fcmd, hcmd;
	isp_pkg::rsp_t r;
	logic push, full, pop, ne;
	logic [7:0] sig0_q, sig1_q, sig2_q, fh_q;

	isp_front u_front (.clk, .arst_n, .in_valid(req.valid), .in_ready(req.ready),
		.req_type(req.req_type), .byte_one(req.byte_one), .byte_two(req.byte_two),
		.byte_three(req.byte_three), .q_push(push), .q_full(full), .q_cmd(fcmd));

	isp_queue u_queue (.clk, .arst_n, .push, .push_cmd(fcmd), .full, .pop,
		.not_empty(ne), .head(hcmd));

	isp_back u_back (.clk, .arst_n, .cmd_valid(ne), .cmd(hcmd), .cmd_pop(pop),
		.sig0(sig0_q), .sig1(sig1_q), .sig2(sig2_q), .fuse_hi(fh_q),
		.rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp(r));

	assign rsp.echo_byte = r.echo_byte;
	assign rsp.read_data = r.read_data;
	assign rsp.status    = r.status;
	assign cfg.ready     = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sig0_q <= 8'h1E; sig1_q <= 8'h93; sig2_q <= 8'h07; fh_q <= 8'hD9;
		end else if (cfg.valid) begin
			case (cfg.index)
				isp_pkg::CFG_SIG0: sig0_q <= cfg.data;
				isp_pkg::CFG_SIG1: sig1_q <= cfg.data;
				isp_pkg::CFG_SIG2: sig2_q <= cfg.data;
				isp_pkg::CFG_FH:   fh_q <= cfg.data;
				default: ;
			endcase
		end
	end
endmodule

// ===== design/isp_checker.sv =====
// Port-level checker of the programming target, bound to the top level.
// Depends on isp_pkg and isp_programming_target_unit_macros.svh.
`timescale 1ns / 1ps
`include "isp_programming_target_unit_macros.svh"
module isp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [7:0] echo_byte,
	input logic [7:0] read_data,
	input logic [1:0] status
);
	logic is_ign, is_unk;

	assign is_ign = rsp_valid && status == isp_pkg::ST_IGNORED;
	assign is_unk = rsp_valid && status == isp_pkg::ST_UNKNOWN;

	`ISP_ASSERT_IMP(a_status_range, clk, arst_n, rsp_valid, status != 2'd3)
	`ISP_ASSERT_IMP(a_ignored_zero, clk, arst_n, is_ign, echo_byte == 8'd0 && read_data == 8'd0)
	`ISP_ASSERT_IMP(a_unknown_nodata, clk, arst_n, is_unk, read_data == 8'd0)
	`ISP_ASSERT_NEXT(a_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(read_data))
endmodule

bind isp_programming_target_unit isp_checker u_chk (.clk(clk), .arst_n(arst_n),
	.rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .echo_byte(rsp.echo_byte),
	.read_data(rsp.read_data), .status(rsp.status));
